// ===== src/b64d_pkg.sv =====
// Shared types, codes and the character classifier for the base64 decoder.
// No dependencies; every other file of the block imports this package.
package b64d_pkg;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_PAD  = 2'd1,
    KIND_BAD  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_CHAR = 2'd1,
    ERR_PAD  = 2'd2,
    ERR_LEN  = 2'd3
  } err_t;

  typedef struct packed {
    kind_t      kind;
    logic [5:0] sextet;
    logic       last;
  } item_t;

  function automatic item_t classify(input logic [7:0] c, input logic last);
    item_t      it;
    logic [7:0] d;
    it.kind   = KIND_BAD;
    it.sextet = 6'd0;
    it.last   = last;
    d         = 8'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d         = c - 8'd65;
      it.kind   = KIND_DATA;
      it.sextet = d[5:0];
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d         = c - 8'd71;
      it.kind   = KIND_DATA;
      it.sextet = d[5:0];
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d         = c + 8'd4;
      it.kind   = KIND_DATA;
      it.sextet = d[5:0];
    end else if (c == 8'h2B) begin
      it.kind   = KIND_DATA;
      it.sextet = 6'd62;
    end else if (c == 8'h2F) begin
      it.kind   = KIND_DATA;
      it.sextet = 6'd63;
    end else if (c == 8'h3D) begin
      it.kind   = KIND_PAD;
    end
    return it;
  endfunction

endpackage

// ===== src/b64d_front.sv =====
// Front stage: accepts characters and registers their class and sextet value.
// Depends on b64d_pkg for item_t and classify().
module b64d_front import b64d_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_code,
  input  logic       last_char,
  input  logic       q_full,
  output logic       q_push,
  output item_t      q_item
);

  logic  fv;
  item_t item;

  assign q_push = fv && !q_full;
  assign full   = fv && q_full;
  assign q_item = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (push && !full) begin
      fv <= 1'b1;
    end else if (q_push) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      item <= classify(char_code, last_char);
    end
  end

endmodule

// ===== src/b64d_queue.sv =====
// Short queue of classified items between the front and back stages.
// Depends on b64d_pkg for item_t and the queue depth constants.
module b64d_queue import b64d_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr,
  input  item_t wr_item,
  output logic  q_full,
  input  logic  rd,
  output logic  q_valid,
  output item_t rd_item
);

  item_t              slots [QDEPTH];
  logic [QPTR_W-1:0]  wptr;
  logic [QPTR_W-1:0]  rptr;
  logic [QCNT_W-1:0]  count;

  assign q_full  = (count == QCNT_W'(QDEPTH));
  assign q_valid = (count != '0);
  assign rd_item = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + 1'b1;
      end
      if (rd) begin
        rptr <= rptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + QCNT_W'(1);
      end else if (rd && !wr) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wptr] <= wr_item;
    end
  end

endmodule

// ===== src/b64d_back.sv =====
// Back stage: quantum tracking, byte assembly, error checks and result register.
// Depends on b64d_pkg for item_t, kind_t and err_t.
module b64d_back import b64d_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  item_t      q_item,
  output logic       q_pop,
  input  logic       pop,
  output logic       empty,
  output logic       has_byte,
  output logic [7:0] data_byte,
  output logic       message_end,
  output logic [1:0] status
);

  logic [1:0] pos, pos_next;
  logic [5:0] held, held_next;
  logic [1:0] pad, pad_next;
  err_t       err, err_next;
  logic       ov;
  logic       has_c, end_c;
  logic [7:0] byte_c;
  err_t       stat_c;

  assign empty = !ov;
  assign q_pop = q_valid && (!ov || pop);

  always_comb begin
    pos_next  = pos + 2'd1;
    held_next = held;
    pad_next  = pad;
    err_next  = err;
    has_c     = 1'b0;
    byte_c    = 8'd0;
    end_c     = 1'b0;
    stat_c    = ERR_NONE;
    unique case (q_item.kind)
      KIND_BAD: begin
        if (err == ERR_NONE) err_next = ERR_CHAR;
      end
      KIND_PAD: begin
        if (pos < 2'd2 || (pad != 2'd0 && pos != 2'd3)) begin
          if (err == ERR_NONE) err_next = ERR_PAD;
        end else if (pad != 2'd3) begin
          pad_next = pad + 2'd1;
        end
      end
      KIND_DATA: begin
        if (pad != 2'd0) begin
          if (err == ERR_NONE) err_next = ERR_PAD;
        end else begin
          unique case (pos)
            2'd0: begin
              held_next = q_item.sextet;
            end
            2'd1: begin
              byte_c    = {held, q_item.sextet[5:4]};
              held_next = {2'b00, q_item.sextet[3:0]};
              has_c     = 1'b1;
            end
            2'd2: begin
              byte_c    = {held[3:0], q_item.sextet[5:2]};
              held_next = {4'b0000, q_item.sextet[1:0]};
              has_c     = 1'b1;
            end
            2'd3: begin
              byte_c    = {held[1:0], q_item.sextet};
              held_next = 6'd0;
              has_c     = 1'b1;
            end
          endcase
        end
      end
      default: begin
        if (err == ERR_NONE) err_next = ERR_CHAR;
      end
    endcase
    if (err_next != ERR_NONE) begin
      has_c  = 1'b0;
      byte_c = 8'd0;
    end
    if (q_item.last) begin
      if (pos_next != 2'd0 && err_next == ERR_NONE) err_next = ERR_LEN;
      stat_c = err_next;
      end_c  = 1'b1;
      if (stat_c != ERR_NONE) begin
        has_c  = 1'b0;
        byte_c = 8'd0;
      end
      pos_next  = 2'd0;
      held_next = 6'd0;
      pad_next  = 2'd0;
      err_next  = ERR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= 2'd0;
      held <= 6'd0;
      pad  <= 2'd0;
      err  <= ERR_NONE;
      ov   <= 1'b0;
    end else begin
      if (q_pop) begin
        pos  <= pos_next;
        held <= held_next;
        pad  <= pad_next;
        err  <= err_next;
        ov   <= 1'b1;
      end else if (pop) begin
        ov   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      has_byte    <= has_c;
      data_byte   <= byte_c;
      message_end <= end_c;
      status      <= stat_c;
    end
  end

endmodule

// ===== src/base64_decoder_with_check_top.sv =====
// Top level of the streaming base64 decoder with error checking.
// Depends on b64d_pkg, b64d_front, b64d_queue and b64d_back.
//
// One base64 character enters per push and one result leaves per pop; the decoder
// sustains one item per clock cycle with both sides free, and the result of an item
// passes the classify register, a queue write and the result register before it is
// on the result ports. Bytes come out after the second, third and fourth
// character of each quantum; status and message_end are valid on the result of the
// character marked last_char, and a nonzero status means the bytes of that message
// are bad.
module base64_decoder_with_check_top import b64d_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_code,
  input  logic       last_char,
  output logic       empty,
  input  logic       pop,
  output logic       has_byte,
  output logic [7:0] data_byte,
  output logic       message_end,
  output logic [1:0] status
);

  logic  f_push, q_full, q_valid, q_pop;
  item_t f_item, q_item;

  b64d_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .char_code (char_code),
    .last_char (last_char),
    .q_full    (q_full),
    .q_push    (f_push),
    .q_item    (f_item)
  );

  b64d_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (f_push),
    .wr_item (f_item),
    .q_full  (q_full),
    .rd      (q_pop),
    .q_valid (q_valid),
    .rd_item (q_item)
  );

  b64d_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .has_byte    (has_byte),
    .data_byte   (data_byte),
    .message_end (message_end),
    .status      (status)
  );

endmodule

// ===== src/b64d_checker.sv =====
// Port-level checks for the base64 decoder top level, with the bind that attaches them.
// Depends on b64d_pkg for the status codes.
module b64d_checker import b64d_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic       pop,
  input logic       has_byte,
  input logic [7:0] data_byte,
  input logic       message_end,
  input logic [1:0] status
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_status_at_end: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (status == ERR_NONE || message_end))
    else $error("error status on a result that is not the message end");

  a_no_byte_on_error: assert property (@(posedge clk) disable iff (rst)
    (!empty && message_end && status != ERR_NONE) |-> !has_byte)
    else $error("byte reported on a failed message end");

  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !has_byte) |-> data_byte == 8'd0)
    else $error("data byte nonzero without a byte");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(data_byte) && $stable(status)))
    else $error("waiting result changed before pop");

endmodule

bind base64_decoder_with_check_top b64d_checker u_b64d_checker (.*);
